// ===== hw/rtl/hmp_track_to_midi_converter_macros.svh =====
// Assertion macros for the HMP track to MIDI converter.
`ifndef HMP_TRACK_TO_MIDI_CONVERTER_MACROS_SVH
`define HMP_TRACK_TO_MIDI_CONVERTER_MACROS_SVH

`ifndef SYNTHESIS
// Check that pre implies post in the same cycle.
`define HTM_ASSERT_IMPL(label, clk, rst_n, pre, post) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |-> (post)) \
		else $error("same-cycle implication failed");
// Check that pre implies post in the next cycle.
`define HTM_ASSERT_NEXT(label, clk, rst_n, pre, post) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |=> (post)) \
		else $error("next-cycle implication failed");
`else
`define HTM_ASSERT_IMPL(label, clk, rst_n, pre, post)
`define HTM_ASSERT_NEXT(label, clk, rst_n, pre, post)
`endif

`endif

// ===== hw/rtl/htm_pkg.sv =====
// Types, codes and helpers shared by the HMP track to MIDI converter.
`timescale 1ns / 1ps
package htm_pkg;

	localparam int DEFAULT_MAX_DELTA_GROUPS = 4;

	// Parser phase
	typedef enum logic [2:0] {
		PH_IDLE,
		PH_DELTA,
		PH_CMD,
		PH_MTYPE,
		PH_MLEN,
		PH_MDATA,
		PH_DATA
	} htm_phase_t;

	// Result kinds
	localparam logic [1:0] KIND_BYTE   = 2'd0;
	localparam logic [1:0] KIND_FINISH = 2'd1;
	localparam logic [1:0] KIND_ERROR  = 2'd2;

	// Error codes
	localparam logic [1:0] ERR_DELTA_LONG = 2'd0;
	localparam logic [1:0] ERR_END_META   = 2'd1;
	localparam logic [1:0] ERR_BAD_CMD    = 2'd2;
	localparam logic [1:0] ERR_LENGTH     = 2'd3;

	// Action selector
	localparam logic ACT_BEGIN = 1'b0;

	// Command and meta codes
	localparam logic [7:0] CMD_META     = 8'hFF;
	localparam logic [7:0] META_END     = 8'h2F;
	localparam logic [3:0] CLS_NOTE_OFF = 4'h8;
	localparam logic [3:0] CLS_NOTE_ON  = 4'h9;
	localparam logic [3:0] CLS_POLY_AT  = 4'hA;
	localparam logic [3:0] CLS_CTRL     = 4'hB;
	localparam logic [3:0] CLS_PROG     = 4'hC;
	localparam logic [3:0] CLS_CHAN_AT  = 4'hD;
	localparam logic [3:0] CLS_PITCH    = 4'hE;

	typedef struct packed {
		logic [1:0]  kind;
		logic [7:0]  midi_byte;
		logic [31:0] count;
		logic [1:0]  err;
	} htm_result_t;

	// Data bytes that follow a channel command; zero marks a bad command.
	function automatic logic [1:0] cmd_data_len(input logic [7:0] b);
		logic [1:0] len;
		unique case (b[7:4])
			CLS_NOTE_OFF, CLS_NOTE_ON, CLS_POLY_AT, CLS_CTRL, CLS_PITCH: len = 2'd2;
			CLS_PROG, CLS_CHAN_AT: len = 2'd1;
			default: len = 2'd0;
		endcase
		return len;
	endfunction

	function automatic htm_result_t mk_byte(input logic [7:0] b);
		htm_result_t r;
		r = '0;
		r.kind = KIND_BYTE;
		r.midi_byte = b;
		return r;
	endfunction

	function automatic htm_result_t mk_finish(input logic [31:0] cnt);
		htm_result_t r;
		r = '0;
		r.kind = KIND_FINISH;
		r.count = cnt;
		return r;
	endfunction

	function automatic htm_result_t mk_fail(input logic [1:0] e);
		htm_result_t r;
		r = '0;
		r.kind = KIND_ERROR;
		r.err = e;
		return r;
	endfunction

endpackage

// ===== hw/rtl/hmp_track_to_midi_converter.sv =====
// Top level: HMP track body to standard MIDI track body converter.
//
//  channel   direction  tdata                               tuser      tlast
//  s_axis    in         [31:0] body_length, [39:32] body_byte  [0] action  -
//  m_axis    out        [7:0] midi_byte, [39:8] count,      [1:0] kind last
//                       [41:40] error_code
//
// Each input transfer is decoded combinationally against the parser state and
// its results (zero to NR, which is MAX_DELTA_GROUPS but at least two) are loaded into a
// result list that drains one output transfer per cycle while m_axis_tready is high.
// The list drain sets the rate at which items are taken.
// A new item is taken while the final result of the previous one is transferred.
// arst_n clears the parser to idle and empties the result list.
`timescale 1ns / 1ps
`include "hmp_track_to_midi_converter_macros.svh"

module hmp_track_to_midi_converter #(
	parameter int MAX_DELTA_GROUPS = htm_pkg::DEFAULT_MAX_DELTA_GROUPS
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [39:0] s_axis_tdata,   // [31:0] body_length, [39:32] body_byte
	input  logic [0:0]  s_axis_tuser,   // [0] action
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [47:0] m_axis_tdata,   // [7:0] midi_byte, [39:8] track_byte_count,
	                                    // [41:40] error_code, [47:42] zero
	output logic [1:0]  m_axis_tuser,   // [1:0] kind
	output logic        m_axis_tlast
);
	import htm_pkg::*;

	localparam int NR = (MAX_DELTA_GROUPS > 2) ? MAX_DELTA_GROUPS : 2;
	localparam int LW = $clog2(NR + 1);
	localparam int CW = $clog2(MAX_DELTA_GROUPS + 1);
	localparam int DD = (MAX_DELTA_GROUPS > 1) ? MAX_DELTA_GROUPS - 1 : 1;

	typedef struct packed {
		logic       fail;
		logic [1:0] err;
		logic       emit_byte;
		logic       emit_delta;
		logic       finish;
		logic       bound;
		logic       store;
	} htm_event_t;

	// Parser state
	htm_phase_t  phase_q, phase_d;
	logic [CW-1:0] delta_count_q, delta_count_d;
	logic [6:0]  sh_q [DD];
	logic [7:0]  running_status_q, running_status_d;
	logic [1:0]  data_left_q, data_left_d;
	logic [7:0]  meta_type_q, meta_type_d;
	logic [7:0]  meta_left_q, meta_left_d;
	logic [31:0] remaining_q, remaining_d;
	logic [31:0] emitted_q, emitted_d;

	// Result list
	htm_result_t res_s1 [NR];
	htm_result_t res_d  [NR];
	logic [LW-1:0] left_q;
	logic [LW-1:0] n_d;
	logic [LW-1:0] nbytes;

	htm_event_t ev;
	logic        s_acc, m_acc, is_begin;
	logic [31:0] body_length, rem_dec;
	logic [7:0]  b;
	logic [1:0]  cls_len;

	assign body_length = s_axis_tdata[31:0];
	assign b           = s_axis_tdata[39:32];
	assign is_begin    = (s_axis_tuser[0] == ACT_BEGIN);
	assign rem_dec     = remaining_q - 32'd1;
	assign cls_len     = cmd_data_len(b);

	assign s_axis_tready = (left_q == '0) || ((left_q == LW'(1)) && m_axis_tready);
	assign s_acc = s_axis_tvalid && s_axis_tready;
	assign m_acc = m_axis_tvalid && m_axis_tready;

	// Decode the incoming transfer against the current phase
	always_comb begin
		ev = '0;
		if (is_begin) begin
			ev.finish = (body_length == 32'd0);
		end else if (phase_q != PH_IDLE) begin
			if (remaining_q == 32'd0) begin
				ev.fail = 1'b1;
				ev.err  = ERR_LENGTH;
			end else begin
				unique case (phase_q)
					PH_DELTA: begin
						if (delta_count_q >= CW'(MAX_DELTA_GROUPS)) begin
							ev.fail = 1'b1;
							ev.err  = ERR_DELTA_LONG;
						end else begin
							ev.store      = 1'b1;
							ev.emit_delta = b[7];
						end
					end
					PH_CMD: begin
						if (b == CMD_META) begin
							ev.emit_byte = 1'b1;
						end else if (cls_len == 2'd0) begin
							ev.fail = 1'b1;
							ev.err  = ERR_BAD_CMD;
						end else begin
							ev.emit_byte = (b != running_status_q);
						end
					end
					PH_DATA: begin
						ev.emit_byte = 1'b1;
						ev.bound     = (data_left_q == 2'd1);
					end
					PH_MTYPE: begin
						ev.emit_byte = 1'b1;
					end
					PH_MLEN: begin
						ev.emit_byte = 1'b1;
						if (meta_type_q == META_END) begin
							if (b != 8'd0) begin
								ev.fail = 1'b1;
								ev.err  = ERR_END_META;
							end else if (rem_dec != 32'd0) begin
								ev.fail = 1'b1;
								ev.err  = ERR_LENGTH;
							end else begin
								ev.finish = 1'b1;
							end
						end else begin
							ev.bound = (b == 8'd0);
						end
					end
					PH_MDATA: begin
						ev.emit_byte = 1'b1;
						ev.bound     = (meta_left_q == 8'd1);
					end
					default: ev = '0;
				endcase
				if (ev.bound && (rem_dec == 32'd0))
					ev.finish = 1'b1;
			end
		end
	end

	// Count the MIDI bytes this transfer emits
	always_comb begin
		if (ev.emit_delta)
			nbytes = LW'(delta_count_q) + LW'(1);
		else if (ev.emit_byte)
			nbytes = LW'(1);
		else
			nbytes = '0;
	end

	// Next parser state
	always_comb begin
		phase_d          = phase_q;
		delta_count_d    = delta_count_q;
		running_status_d = running_status_q;
		data_left_d      = data_left_q;
		meta_type_d      = meta_type_q;
		meta_left_d      = meta_left_q;
		remaining_d      = remaining_q;
		emitted_d        = emitted_q;
		if (is_begin) begin
			remaining_d      = body_length;
			emitted_d        = 32'd0;
			delta_count_d    = '0;
			data_left_d      = 2'd0;
			meta_type_d      = 8'd0;
			meta_left_d      = 8'd0;
			running_status_d = 8'd0;
			phase_d          = PH_DELTA;
		end else if (phase_q != PH_IDLE) begin
			if (remaining_q != 32'd0)
				remaining_d = rem_dec;
			emitted_d = emitted_q + 32'(nbytes);
			unique case (phase_q)
				PH_DELTA: begin
					if (ev.store) begin
						delta_count_d = delta_count_q + CW'(1);
						if (b[7])
							phase_d = PH_CMD;
					end
				end
				PH_CMD: begin
					if (b == CMD_META) begin
						phase_d = PH_MTYPE;
					end else if (cls_len != 2'd0) begin
						data_left_d      = cls_len;
						running_status_d = b;
						phase_d          = PH_DATA;
					end
				end
				PH_DATA: data_left_d = data_left_q - 2'd1;
				PH_MTYPE: begin
					meta_type_d = b;
					phase_d     = PH_MLEN;
				end
				PH_MLEN: begin
					meta_left_d = b;
					if ((meta_type_q != META_END) && (b != 8'd0))
						phase_d = PH_MDATA;
				end
				PH_MDATA: meta_left_d = meta_left_q - 8'd1;
				default: phase_d = PH_IDLE;
			endcase
			if (ev.bound) begin
				delta_count_d = '0;
				phase_d       = PH_DELTA;
			end
		end
		if (ev.fail || ev.finish)
			phase_d = PH_IDLE;
	end

	// Build the result list for this transfer
	always_comb begin
		logic [31:0] fin_cnt;
		fin_cnt = is_begin ? 32'd0 : emitted_q + 32'(nbytes);
		for (int k = 0; k < NR; k++)
			res_d[k] = '0;
		n_d = '0;
		if (ev.emit_delta) begin
			// newest group first; continuation bit on all but the oldest
			res_d[0] = mk_byte({delta_count_q != '0, b[6:0]});
			for (int k = 1; k < MAX_DELTA_GROUPS; k++) begin
				if (CW'(k) <= delta_count_q)
					res_d[k] = mk_byte({CW'(k) != delta_count_q, sh_q[k-1]});
			end
			n_d = nbytes;
		end else if (ev.emit_byte) begin
			res_d[0] = mk_byte(b);
			n_d = LW'(1);
			if (ev.fail) begin
				res_d[1] = mk_fail(ev.err);
				n_d = LW'(2);
			end else if (ev.finish) begin
				res_d[1] = mk_finish(fin_cnt);
				n_d = LW'(2);
			end
		end else if (ev.fail) begin
			res_d[0] = mk_fail(ev.err);
			n_d = LW'(1);
		end else if (ev.finish) begin
			res_d[0] = mk_finish(fin_cnt);
			n_d = LW'(1);
		end
	end

	// Parser state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q          <= PH_IDLE;
			delta_count_q    <= '0;
			running_status_q <= 8'd0;
			data_left_q      <= 2'd0;
			meta_type_q      <= 8'd0;
			meta_left_q      <= 8'd0;
			remaining_q      <= 32'd0;
			emitted_q        <= 32'd0;
		end else if (s_acc) begin
			phase_q          <= phase_d;
			delta_count_q    <= delta_count_d;
			running_status_q <= running_status_d;
			data_left_q      <= data_left_d;
			meta_type_q      <= meta_type_d;
			meta_left_q      <= meta_left_d;
			remaining_q      <= remaining_d;
			emitted_q        <= emitted_d;
		end
	end

	// Delta group shift line, newest group at the bottom
	always_ff @(posedge clk) begin
		if (s_acc && ev.store) begin
			sh_q[0] <= b[6:0];
			for (int j = 1; j < DD; j++)
				sh_q[j] <= sh_q[j-1];
		end
	end

	// Result list occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q <= '0;
		end else if (s_acc && (n_d != '0)) begin
			left_q <= n_d;
		end else if (m_acc) begin
			left_q <= left_q - LW'(1);
		end
	end

	// Load a new list or advance the head on each output transfer
	always_ff @(posedge clk) begin
		if (s_acc && (n_d != '0)) begin
			res_s1 <= res_d;
		end else if (m_acc) begin
			for (int j = 0; j < NR - 1; j++)
				res_s1[j] <= res_s1[j+1];
		end
	end

	assign m_axis_tvalid = (left_q != '0);
	assign m_axis_tlast  = (left_q == LW'(1));
	assign m_axis_tuser  = res_s1[0].kind;
	assign m_axis_tdata  = {6'd0, res_s1[0].err, res_s1[0].count, res_s1[0].midi_byte};

	// An empty track finishes with the very next output transfer
	`HTM_ASSERT_NEXT(a_empty_finish, clk, arst_n, (s_acc && is_begin && (body_length == 32'd0)), (m_axis_tvalid && (m_axis_tuser == KIND_FINISH) && m_axis_tlast))
	// An error is always the final result of its item
	`HTM_ASSERT_IMPL(a_error_last, clk, arst_n, (m_axis_tvalid && (m_axis_tuser == KIND_ERROR)), m_axis_tlast)
	// While an error is pending the parser already sits idle
	`HTM_ASSERT_IMPL(a_error_idle, clk, arst_n, (m_axis_tvalid && (m_axis_tuser == KIND_ERROR)), (phase_q == PH_IDLE))

endmodule
